@@ rtl/spq_pkg.sv @@
// Package for the sorted priority queue: depth, widths, status codes and the
// per-cell control struct. Depends on nothing; used by every module in rtl/.
`default_nettype none
package spq_pkg;

  localparam int DEPTH   = 8;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int DATA_W  = 48;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Control broadcast to one cell for the current beat.
  typedef struct packed {
    logic enq;       // a pair is being inserted this cycle
    logic deq;       // the front entry is being removed this cycle
    logic occupied;  // this cell holds a live entry
    logic at_tail;   // this cell is the first free slot
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/spq_cell.sv @@
// One storage cell of the sorted chain: a value and priority pair with its
// compare and its left/right shift selection. Depends on spq_pkg.
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic [VALUE_W-1:0]       new_value,
  input  wire logic signed [PRIO_W-1:0] new_priority,
  input  wire logic [VALUE_W-1:0]       left_value,
  input  wire logic signed [PRIO_W-1:0] left_priority,
  input  wire logic                     left_gt,
  input  wire logic [VALUE_W-1:0]       right_value,
  input  wire logic signed [PRIO_W-1:0] right_priority,
  output logic [VALUE_W-1:0]            value,
  output logic signed [PRIO_W-1:0]      prio,
  output logic                          gt
);

  logic load;

  // Strictly larger priority moves up, so equal priorities keep arrival order.
  assign gt   = ctrl.occupied && (prio > new_priority);
  assign load = ctrl.enq ? (gt || ctrl.at_tail) : ctrl.deq;

  always_ff @(posedge clk) begin
    if (load) begin
      if (ctrl.deq) begin
        value <= right_value;
        prio  <= right_priority;
      end else if (left_gt) begin
        value <= left_value;
        prio  <= left_priority;
      end else begin
        value <= new_value;
        prio  <= new_priority;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/sorted_priority_queue_unit.sv @@
// Top level of the sorted priority queue: occupancy count, a row of spq_cell
// instances and the registered result beat. Depends on spq_pkg and spq_cell.
//
// Channel   Direction  tdata (low bit up)                 tuser
// s_*       in         item_value[31:0], item_priority    operation
// m_*       out        out_value[31:0], out_priority      status
//
// Every accepted beat is handled in the cycle it is accepted: all cells compare
// against the new priority at once and either shift up to open a slot, shift
// down to close the front, or hold. The result beat is registered and appears
// on the master side in the cycle after its input is accepted, and the block
// takes one beat per cycle while m_tready stays high.
// The input is stalled only while a result beat waits and m_tready is low.
// Reset (synchronous, active high) empties the queue and drops any pending
// result; the cell contents are left as they are and are never read unwritten.
`default_nettype none
module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,   // item_value[31:0], item_priority[47:32]
  input  wire logic              s_tuser,   // operation
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [DATA_W-1:0]      m_tdata,   // out_value[31:0], out_priority[47:32]
  output logic [1:0]             m_tuser    // status
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                     accept;
  logic                     is_deq;
  logic                     is_full;
  logic                     is_empty;
  logic                     do_enq;
  logic                     do_deq;
  logic [VALUE_W-1:0]       in_value;
  logic signed [PRIO_W-1:0] in_priority;

  status_t                  res_status;
  logic [VALUE_W-1:0]       res_value;
  logic signed [PRIO_W-1:0] res_priority;

  // Cell outputs and their neighbour connections.
  cell_ctrl_t               ctrl     [DEPTH];
  logic [VALUE_W-1:0]       cell_val [DEPTH];
  logic signed [PRIO_W-1:0] cell_pri [DEPTH];
  logic                     cell_gt  [DEPTH];
  logic [VALUE_W-1:0]       lv       [DEPTH];
  logic signed [PRIO_W-1:0] lp       [DEPTH];
  logic                     lg       [DEPTH];
  logic [VALUE_W-1:0]       rv       [DEPTH];
  logic signed [PRIO_W-1:0] rp       [DEPTH];

  assign s_tready    = !m_tvalid || m_tready;
  assign accept      = s_tvalid && s_tready;
  assign is_deq      = (s_tuser == OP_DEQUEUE);
  assign is_full     = (count == CNT_W'(DEPTH));
  assign is_empty    = (count == '0);
  assign do_enq      = accept && !is_deq && !is_full;
  assign do_deq      = accept && is_deq && !is_empty;
  assign in_value    = s_tdata[VALUE_W-1:0];
  assign in_priority = s_tdata[VALUE_W+PRIO_W-1:VALUE_W];

  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + 1'b1;
    end else if (do_deq) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign ctrl[i].enq      = do_enq;
      assign ctrl[i].deq      = do_deq;
      assign ctrl[i].occupied = (CNT_W'(i) < count);
      assign ctrl[i].at_tail  = (CNT_W'(i) == count);

      // The front cell has nothing to its left; the last cell refills from
      // itself on removal, which is harmless as it then lies beyond the count.
      if (i == 0) begin : g_first
        assign lv[i] = '0;
        assign lp[i] = '0;
        assign lg[i] = 1'b0;
      end else begin : g_inner
        assign lv[i] = cell_val[i-1];
        assign lp[i] = cell_pri[i-1];
        assign lg[i] = cell_gt[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign rv[i] = cell_val[i];
        assign rp[i] = cell_pri[i];
      end else begin : g_notlast
        assign rv[i] = cell_val[i+1];
        assign rp[i] = cell_pri[i+1];
      end

      spq_cell u_cell (
        .clk            (clk),
        .ctrl           (ctrl[i]),
        .new_value      (in_value),
        .new_priority   (in_priority),
        .left_value     (lv[i]),
        .left_priority  (lp[i]),
        .left_gt        (lg[i]),
        .right_value    (rv[i]),
        .right_priority (rp[i]),
        .value          (cell_val[i]),
        .prio           (cell_pri[i]),
        .gt             (cell_gt[i])
      );
    end
  endgenerate

  // Result for the beat being accepted; the front cell is read before it shifts.
  always_comb begin
    res_value    = '0;
    res_priority = '0;
    if (is_deq) begin
      if (is_empty) begin
        res_status = ST_EMPTY;
      end else begin
        res_status   = ST_DEQUEUED;
        res_value    = cell_val[0];
        res_priority = cell_pri[0];
      end
    end else begin
      res_status = is_full ? ST_FULL : ST_STORED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {res_priority, res_value};
      m_tuser <= res_status;
    end
  end

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  // An insert into a full queue is dropped and reported as such.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_deq && is_full) |=> (count == $past(count)) && (m_tuser == ST_FULL))
    else $error("insert into full queue not dropped");

  // A removal from a non-empty queue takes exactly one entry.
  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    (accept && is_deq && !is_empty) |=> (count == $past(count) - 1'b1)
      && (m_tuser == ST_DEQUEUED))
    else $error("removal did not take one entry");

  // A removal from an empty queue answers empty with zero payload.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && is_deq && is_empty) |=> (m_tuser == ST_EMPTY) && (m_tdata == '0))
    else $error("empty removal result wrong");

  // Every accepted beat leaves a result beat waiting.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted beat produced no result");

endmodule
`default_nettype wire

@@ dv/sorted_priority_queue_unit_tb.sv @@
// Self-checking testbench for sorted_priority_queue_unit: it drives random and
// directed enqueue and dequeue beats and checks every result beat against a
// behavioural copy of the sorted queue. Depends on spq_pkg and the RTL in rtl/.
`default_nettype none
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  // What the queue should answer for one accepted beat.
  typedef struct {
    status_t                    status;
    logic [VALUE_W-1:0]         value;
    logic signed [PRIO_W-1:0]   prio;
  } queue_answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  wire logic         s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // item_value[31:0], item_priority[47:32]
  logic              s_tuser = 1'b0; // operation
  wire logic         m_tvalid;
  logic              m_tready = 1'b0;
  wire logic [DATA_W-1:0] m_tdata;   // out_value[31:0], out_priority[47:32]
  wire logic [1:0]   m_tuser;        // status

  // Shadow copy of the sorted array, kept in ascending priority order.
  logic [VALUE_W-1:0]        shadow_values [DEPTH];
  logic signed [PRIO_W-1:0]  shadow_prios  [DEPTH];
  int                        shadow_count;

  queue_answer_t awaited_answers[$];

  // When set, neither side inserts idle cycles between beats.
  bit no_idle = 1'b0;

  int mismatches   = 0;
  int beats_sent   = 0;
  int beats_seen   = 0;
  int seen_stored  = 0;
  int seen_full    = 0;
  int seen_served  = 0;
  int seen_empty   = 0;

  sorted_priority_queue_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  // Updates the shadow queue for one accepted beat and records the answer
  // that the block owes for it. Ties go behind every entry of equal priority.
  function automatic void predict_answer(op_t op, logic [VALUE_W-1:0] val,
                                         logic signed [PRIO_W-1:0] pri);
    queue_answer_t ans;
    int pos;
    int i;
    ans.value = '0;
    ans.prio  = '0;
    if (op == OP_ENQUEUE) begin
      if (shadow_count == DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        pos = shadow_count;
        while (pos > 0 && shadow_prios[pos-1] > pri) begin
          shadow_values[pos] = shadow_values[pos-1];
          shadow_prios[pos]  = shadow_prios[pos-1];
          pos--;
        end
        shadow_values[pos] = val;
        shadow_prios[pos]  = pri;
        shadow_count++;
        ans.status = ST_STORED;
      end
    end else if (shadow_count == 0) begin
      ans.status = ST_EMPTY;
    end else begin
      ans.value = shadow_values[0];
      ans.prio  = shadow_prios[0];
      for (i = 1; i < shadow_count; i++) begin
        shadow_values[i-1] = shadow_values[i];
        shadow_prios[i-1]  = shadow_prios[i];
      end
      shadow_count--;
      ans.status = ST_DEQUEUED;
    end
    awaited_answers.push_back(ans);
  endfunction

  // Presents one beat on the slave side after a random gap and holds it until
  // it is taken. tvalid is left high so that a following beat can go straight
  // out; the caller lowers it once the stimulus is done.
  task automatic send_beat(op_t op, logic [VALUE_W-1:0] val,
                           logic signed [PRIO_W-1:0] pri);
    int gap;
    gap = no_idle ? 0 : $urandom_range(18, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {pri, val};
    do @(posedge clk); while (!s_tready);
    predict_answer(op, val, pri);
    beats_sent++;
  endtask

  // Priority draws: full range, a narrow band that forces plenty of ties, or
  // the extremes of the signed range.
  function automatic logic signed [PRIO_W-1:0] draw_priority(int mode);
    int t;
    case (mode)
      0: begin
        t = int'($urandom_range(4, 0)) - 2;
        return PRIO_W'(t);
      end
      1: begin
        case ($urandom_range(3, 0))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value();
    case ($urandom_range(7, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // A dequeue on an empty queue, twice in a row.
  task automatic test_empty_dequeue();
    send_beat(OP_DEQUEUE, 32'h0, 16'sh0);
    send_beat(OP_DEQUEUE, 32'hFFFF_FFFF, 16'shFFFF);
  endtask

  // Fills the queue with extreme values and priorities, ties among them, and
  // then pushes two more pairs that must be refused as full.
  task automatic test_fill_and_overflow();
    send_beat(OP_ENQUEUE, 32'h7FFF_FFFF, 16'sh0000);
    send_beat(OP_ENQUEUE, 32'h8000_0000, 16'sh7FFF);
    send_beat(OP_ENQUEUE, 32'h0000_0000, 16'sh8000);
    send_beat(OP_ENQUEUE, 32'hFFFF_FFFF, 16'sh0000);
    send_beat(OP_ENQUEUE, 32'h0000_0005, 16'sh7FFF);
    send_beat(OP_ENQUEUE, 32'h0000_0006, 16'sh8000);
    send_beat(OP_ENQUEUE, 32'hA5A5_5A5A, 16'shFFFF);
    send_beat(OP_ENQUEUE, 32'h5A5A_A5A5, 16'sh0001);
    send_beat(OP_ENQUEUE, 32'hFFFF_FFFF, 16'sh8000);
    send_beat(OP_ENQUEUE, 32'h8000_0000, 16'sh7FFF);
  endtask

  // Drains the full queue back to back and asks once more when it is empty.
  task automatic test_drain();
    int i;
    no_idle = 1'b1;
    for (i = 0; i <= DEPTH; i++) begin
      send_beat(OP_DEQUEUE, $urandom, PRIO_W'($urandom));
    end
    no_idle = 1'b0;
  endtask

  // Random traffic in blocks: some lean towards filling the queue, some
  // towards draining it, so that both full and empty are reached often.
  // Some blocks also run with no idle cycles at all.
  task automatic test_random(int n_items);
    int   sent;
    int   block_len;
    int   enq_pct;
    int   prio_mode;
    op_t  op;
    sent = 0;
    while (sent < n_items) begin
      block_len = $urandom_range(40, 15);
      case ($urandom_range(2, 0))
        0: enq_pct = 80;
        1: enq_pct = 25;
        default: enq_pct = 55;
      endcase
      prio_mode = $urandom_range(2, 0);
      no_idle = ($urandom_range(3, 0) == 0);
      repeat (block_len) begin
        op = ($urandom_range(99, 0) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        send_beat(op, draw_value(), draw_priority(prio_mode));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: stalls for a random number of cycles before each beat, then
  // takes it and checks it against the oldest awaited answer.
  initial begin : result_checker
    int stall;
    queue_answer_t ans;
    status_t got_status;
    logic [VALUE_W-1:0] got_value;
    logic signed [PRIO_W-1:0] got_prio;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(18, 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      got_status = status_t'(m_tuser);
      got_value  = m_tdata[VALUE_W-1:0];
      got_prio   = m_tdata[VALUE_W +: PRIO_W];
      beats_seen++;
      case (got_status)
        ST_STORED:   seen_stored++;
        ST_FULL:     seen_full++;
        ST_DEQUEUED: seen_served++;
        default:     seen_empty++;
      endcase
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result beat %0d arrived with nothing awaited: status %0d value %h prio %h",
                   beats_seen, got_status, got_value, got_prio);
      end else begin
        ans = awaited_answers.pop_front();
        if (got_status != ans.status || got_value !== ans.value || got_prio !== ans.prio) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result beat %0d: expected status %0d value %h prio %h, got %0d %h %h",
                     beats_seen, ans.status, ans.value, ans.prio,
                     got_status, got_value, got_prio);
        end
      end
    end
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    shadow_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_dequeue();
    test_fill_and_overflow();
    test_drain();
    test_random(520);
    s_tvalid <= 1'b0;

    // Wait for every awaited answer, then keep the clock running so that a stray
    // extra beat would still be caught.
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d beats and checked %0d result beats.", beats_sent, beats_seen);
    $display("Stored %0d, refused as full %0d, served %0d, empty answers %0d.",
             seen_stored, seen_full, seen_served, seen_empty);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
dv/sorted_priority_queue_unit_tb.sv
